/* rtl/bmp24_to_framebuffer_scaler_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the BMP framebuffer scaler.
// Shared helpers for the concurrent checks bound to the top level.
// ----------------------------------------------------------------------------
`ifndef BMP24_TO_FRAMEBUFFER_SCALER_ASSERT_SVH
`define BMP24_TO_FRAMEBUFFER_SCALER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BMPFB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmpfb check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BMPFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmpfb check failed");

`endif

/* rtl/bmpfb_pkg.sv */
// ----------------------------------------------------------------------------
// bmpfb_pkg
// Types and constants shared by the BMP to framebuffer scaler modules.
// ----------------------------------------------------------------------------
package bmpfb_pkg;

   localparam int COORD_BITS      = 11;
   localparam int SCREEN_BITS     = COORD_BITS + 1;
   localparam int ADDR_BITS       = 22;
   localparam int PIXEL_BITS      = 24;
   localparam int SCREEN_STRIDE   = 800;
   localparam int SCREEN_LAST_ROW = 479;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 11;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_HEIGHT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COL_STEP    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_STEP    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_X    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_Y    = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_BORDER = 3'd7;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       image_start;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  fb_address;
      logic [PIXEL_BITS-1:0] pixel_word;
      logic                  image_done;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] src_width;
      logic [COORD_BITS-1:0] dst_width;
      logic [COORD_BITS-1:0] dst_height;
      logic [COORD_BITS-1:0] col_step;
      logic [COORD_BITS-1:0] row_step;
      logic [COORD_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0] origin_y;
      logic                  clip_border;
   } cfg_type;

   typedef struct packed {
      logic [SCREEN_BITS-1:0] screen_col;
      logic [SCREEN_BITS-1:0] screen_row;
      logic [PIXEL_BITS-1:0]  pixel;
      logic                   done;
   } cand_type;

endpackage

/* rtl/bmpfb_link_queue.sv */
// ----------------------------------------------------------------------------
// bmpfb_link_queue
// Two-entry queue of selected pixels between the byte front end and the
// address back end.
// ----------------------------------------------------------------------------
module bmpfb_link_queue
   import bmpfb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cand_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output cand_type head
);

   logic [1:0] count_ff, count_in;
   cand_type   slot0_ff, slot0_in;
   cand_type   slot1_ff, slot1_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = slot0_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      if (do_pop) begin
         slot0_in = (count_ff == 2'd2) ? slot1_ff : push_data;
      end else if (count_ff == 2'd0) begin
         slot0_in = push_data;
      end else begin
         slot0_in = slot0_ff;
      end
      if (do_push && ((count_ff == 2'd1 && !do_pop) || (count_ff == 2'd2 && do_pop))) begin
         slot1_in = push_data;
      end else begin
         slot1_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

/* rtl/bmpfb_front.sv */
// ----------------------------------------------------------------------------
// bmpfb_front
// Groups pixel bytes as blue, green, red, skips row padding and picks the
// source rows and columns that land in the output image.
// ----------------------------------------------------------------------------
module bmpfb_front
   import bmpfb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     beat_valid,
   input  req_type  beat,
   output logic     cand_push,
   output cand_type cand_data
);

   logic [1:0]            phase_ff, phase_in, phase_c;
   logic [1:0]            pad_ff, pad_in, pad_c;
   logic [COORD_BITS-1:0] src_col_ff, src_col_in, src_col_c;
   logic [COORD_BITS-1:0] src_row_ff, src_row_in, src_row_c;
   logic [COORD_BITS-1:0] out_col_ff, out_col_in, out_col_c;
   logic [COORD_BITS-1:0] out_row_ff, out_row_in, out_row_c;
   logic [COORD_BITS-1:0] sel_col_ff, sel_col_in, sel_col_c;
   logic [COORD_BITS-1:0] sel_row_ff, sel_row_in, sel_row_c;
   logic [15:0]           hold_ff, hold_in;
   logic                  row_sel, col_sel, row_end, advance, emit;
   logic [COORD_BITS-1:0] rows_left;

   always_comb begin
      phase_c   = beat.image_start ? 2'd0 : phase_ff;
      pad_c     = beat.image_start ? 2'd0 : pad_ff;
      src_col_c = beat.image_start ? '0 : src_col_ff;
      src_row_c = beat.image_start ? '0 : src_row_ff;
      out_col_c = beat.image_start ? '0 : out_col_ff;
      out_row_c = beat.image_start ? '0 : out_row_ff;
      sel_col_c = beat.image_start ? '0 : sel_col_ff;
      sel_row_c = beat.image_start ? '0 : sel_row_ff;

      row_sel = (src_row_c == sel_row_c) && (out_row_c < cfg.dst_height);
      col_sel = row_sel && (src_col_c == sel_col_c) && (out_col_c < cfg.dst_width);
      row_end = (src_col_c == COORD_BITS'(cfg.src_width - 11'd1));

      phase_in   = phase_c;
      pad_in     = pad_c;
      src_col_in = src_col_c;
      src_row_in = src_row_c;
      out_col_in = out_col_c;
      out_row_in = out_row_c;
      sel_col_in = sel_col_c;
      sel_row_in = sel_row_c;
      hold_in    = hold_ff;
      advance    = 1'b0;
      emit       = 1'b0;

      if (pad_c != 2'd0) begin
         pad_in  = pad_c - 2'd1;
         advance = (pad_c == 2'd1);
      end else if (phase_c == 2'd0) begin
         hold_in  = {hold_ff[15:8], beat.pixel_byte};
         phase_in = 2'd1;
      end else if (phase_c == 2'd1) begin
         hold_in  = {beat.pixel_byte, hold_ff[7:0]};
         phase_in = 2'd2;
      end else begin
         phase_in = 2'd0;
         if (col_sel) begin
            emit       = 1'b1;
            out_col_in = out_col_c + 11'd1;
            sel_col_in = sel_col_c + cfg.col_step;
         end
         if (row_end) begin
            if (cfg.src_width[1:0] == 2'd0) begin
               advance = 1'b1;
            end else begin
               pad_in = cfg.src_width[1:0];
            end
         end else begin
            src_col_in = src_col_c + 11'd1;
         end
      end

      if (advance) begin
         if (row_sel) begin
            out_row_in = out_row_c + 11'd1;
            sel_row_in = sel_row_c + cfg.row_step;
         end
         src_row_in = src_row_c + 11'd1;
         src_col_in = '0;
         out_col_in = '0;
         sel_col_in = '0;
      end

      rows_left            = cfg.dst_height - 11'd1 - out_row_c;
      cand_push            = beat_valid && emit;
      cand_data.screen_col = {1'b0, cfg.origin_x} + {1'b0, out_col_c};
      cand_data.screen_row = {1'b0, cfg.origin_y} + {1'b0, rows_left};
      cand_data.pixel      = {beat.pixel_byte, hold_ff};
      cand_data.done       = (out_col_c == COORD_BITS'(cfg.dst_width - 11'd1)) &&
                             (out_row_c == COORD_BITS'(cfg.dst_height - 11'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 2'd0;
         pad_ff     <= 2'd0;
         src_col_ff <= '0;
         src_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         sel_col_ff <= '0;
         sel_row_ff <= '0;
         hold_ff    <= '0;
      end else if (beat_valid) begin
         phase_ff   <= phase_in;
         pad_ff     <= pad_in;
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         sel_col_ff <= sel_col_in;
         sel_row_ff <= sel_row_in;
         hold_ff    <= hold_in;
      end
   end

endmodule

/* rtl/bmpfb_back.sv */
// ----------------------------------------------------------------------------
// bmpfb_back
// Turns a selected pixel into a framebuffer word address, drops border
// pixels when clipping is on, and holds results in a two-entry output queue.
// ----------------------------------------------------------------------------
module bmpfb_back
   import bmpfb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     link_empty,
   input  cand_type link_head,
   output logic     link_pop,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_data
);

   logic [1:0] count_ff, count_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   rsp_type    result;
   logic       drop, full, do_push, do_pop;

   always_comb begin
      drop = cfg.clip_border &&
             ((link_head.screen_col == '0) ||
              (link_head.screen_col >= SCREEN_BITS'(SCREEN_STRIDE - 1)) ||
              (link_head.screen_row == '0) ||
              (link_head.screen_row >= SCREEN_BITS'(SCREEN_LAST_ROW)));
      result.fb_address = ADDR_BITS'(link_head.screen_col) +
                          ADDR_BITS'(ADDR_BITS'(link_head.screen_row) *
                                     ADDR_BITS'(SCREEN_STRIDE));
      result.pixel_word = link_head.pixel;
      result.image_done = link_head.done;
   end

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_data = slot0_ff;
   assign link_pop = !link_empty && !full;
   assign do_push  = link_pop && !drop;
   assign do_pop   = pop && !empty;

   always_comb begin
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      if (do_pop) begin
         slot0_in = (count_ff == 2'd2) ? slot1_ff : result;
      end else if (count_ff == 2'd0) begin
         slot0_in = result;
      end else begin
         slot0_in = slot0_ff;
      end
      if (do_push && ((count_ff == 2'd1 && !do_pop) || (count_ff == 2'd2 && do_pop))) begin
         slot1_in = result;
      end else begin
         slot1_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

/* rtl/bmp24_to_framebuffer_scaler.sv */
// Path: a red byte, once accepted, is written into the link queue, and the back end
// then moves it into the output queue, whose head drives rsp_data.
// Throughput: one byte per cycle while full is low.
// Reset: synchronous; clears counters and queues and loads the register defaults
// (800, 800, 480, 1, 1, 0, 0, 0).
// ----------------------------------------------------------------------------
// bmp24_to_framebuffer_scaler
// Unpacks 24-bit BMP pixel bytes, decimates to the output size and emits
// framebuffer word writes with the image flipped vertically, less border pixels when clipping is on.
// ----------------------------------------------------------------------------
module bmp24_to_framebuffer_scaler
   import bmpfb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  req_type                   req_data,
   output logic                      empty,
   input  logic                      pop,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     beat_valid;
   logic     cand_push;
   cand_type cand_data;
   logic     link_full, link_empty, link_pop;
   cand_type link_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:   cfg_in.src_width   = csr_wdata;
            CSR_DST_WIDTH:   cfg_in.dst_width   = csr_wdata;
            CSR_DST_HEIGHT:  cfg_in.dst_height  = csr_wdata;
            CSR_COL_STEP:    cfg_in.col_step    = csr_wdata;
            CSR_ROW_STEP:    cfg_in.row_step    = csr_wdata;
            CSR_ORIGIN_X:    cfg_in.origin_x    = csr_wdata;
            CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_wdata;
            CSR_CLIP_BORDER: cfg_in.clip_border = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width   <= 11'd800;
         cfg_ff.dst_width   <= 11'd800;
         cfg_ff.dst_height  <= 11'd480;
         cfg_ff.col_step    <= 11'd1;
         cfg_ff.row_step    <= 11'd1;
         cfg_ff.origin_x    <= 11'd0;
         cfg_ff.origin_y    <= 11'd0;
         cfg_ff.clip_border <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign full       = link_full;
   assign beat_valid = push && !link_full;

   bmpfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .beat_valid (beat_valid),
      .beat       (req_data),
      .cand_push  (cand_push),
      .cand_data  (cand_data)
   );

   bmpfb_link_queue u_link (
      .clock     (clock),
      .reset     (reset),
      .push      (cand_push),
      .push_data (cand_data),
      .full      (link_full),
      .pop       (link_pop),
      .empty     (link_empty),
      .head      (link_head)
   );

   bmpfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .link_empty (link_empty),
      .link_head  (link_head),
      .link_pop   (link_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

/* rtl/bmpfb_checker.sv */
// ----------------------------------------------------------------------------
// bmpfb_checker
// Port-level checks for the BMP framebuffer scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "bmp24_to_framebuffer_scaler_assert.svh"

module bmpfb_checker
   import bmpfb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // Reset leaves both queues drained.
   `BMPFB_ASSERT_NEXT(a_reset_drains, clock, 1'b0, reset, empty && !full)

   // The input side backs up only when a result is already waiting.
   `BMPFB_ASSERT_NOW(a_full_needs_result, clock, reset, full, !empty)

   // A waiting result beat holds until it is taken.
   `BMPFB_ASSERT_NEXT(a_result_holds, clock, reset, !empty && !pop,
                      !empty && $stable(rsp_data))

   // A push into a full block is not taken, and it cannot leave the block full
   // without a waiting result.
   `BMPFB_ASSERT_NEXT(a_full_stays_backed, clock, reset, full && push && !pop, !empty)

endmodule

bind bmp24_to_framebuffer_scaler bmpfb_checker u_bmpfb_checker (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

/* tb/tb_bmp24_to_framebuffer_scaler.sv */
// ----------------------------------------------------------------------------
// tb_bmp24_to_framebuffer_scaler
// Streams BMP pixel bytes into the scaler and checks every framebuffer write
// against a cycle-free model of the unpacking, decimation, flip and clipping.
// A short table of directed bytes comes first, then special configurations
// and randomized images under several push and pop idling mixes.
// ----------------------------------------------------------------------------
module tb_bmp24_to_framebuffer_scaler;
   import bmpfb_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int DIRECTED_ROWS = 18;
   localparam int PHASE_BYTES   = 48;
   localparam int RANDOM_PHASES = 8;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      req_type beat;
      logic    given;
      rsp_type want;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   req_type                   req_data = '0;
   logic                      empty;
   logic                      pop = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_SRC_WIDTH;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   cfg_type               shadow;
   logic [1:0]            byte_phase;
   logic [1:0]            pad_left;
   logic [COORD_BITS-1:0] src_col;
   logic [COORD_BITS-1:0] src_row;
   logic [COORD_BITS-1:0] out_col;
   logic [COORD_BITS-1:0] out_row;
   logic [COORD_BITS-1:0] next_col;
   logic [COORD_BITS-1:0] next_row;
   logic [15:0]           bg_hold;

   rsp_type pending_pixels [$];
   rsp_type want_pixel;
   int      send_idle_pct = 0;
   int      pop_stall_pct = 0;
   int      bytes_sent = 0;
   int      pixels_checked = 0;
   int      error_count = 0;
   int      cycle_count = 0;

   directed_row_type directed [DIRECTED_ROWS] = '{
      '{'{8'hFF, 1'b1}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b1, '{22'd383200, 24'hFF00FF, 1'b0}},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b1, '{22'd383201, 24'h00FF00, 1'b0}},
      '{'{8'h5A, 1'b0}, 1'b0, '0},
      '{'{8'hA5, 1'b0}, 1'b0, '0},
      '{'{8'h3C, 1'b0}, 1'b0, '0},
      '{'{8'h12, 1'b1}, 1'b0, '0},
      '{'{8'h34, 1'b0}, 1'b0, '0},
      '{'{8'h56, 1'b0}, 1'b1, '{22'd383200, 24'h563412, 1'b0}},
      '{'{8'h80, 1'b0}, 1'b0, '0},
      '{'{8'h01, 1'b0}, 1'b0, '0},
      '{'{8'h7F, 1'b0}, 1'b0, '0},
      '{'{8'hFE, 1'b0}, 1'b0, '0},
      '{'{8'h7F, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b0}, 1'b0, '0}
   };

   bmp24_to_framebuffer_scaler dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit row_kept();
      return src_row == next_row && out_row < shadow.dst_height;
   endfunction

   function automatic void next_source_row();
      if (row_kept()) begin
         out_row  = out_row + 1'b1;
         next_row = next_row + shadow.row_step;
      end
      src_row  = src_row + 1'b1;
      src_col  = '0;
      out_col  = '0;
      next_col = '0;
   endfunction

   function automatic void clear_counters();
      byte_phase = '0;
      pad_left   = '0;
      src_col    = '0;
      src_row    = '0;
      out_col    = '0;
      out_row    = '0;
      next_col   = '0;
      next_row   = '0;
   endfunction

   function automatic int row_padding(input int width);
      return (4 - (3 * width) % 4) % 4;
   endfunction

   // Advances the model by one byte; returns 1 when a framebuffer write is due.
   function automatic bit scale_byte(input req_type beat_in, output rsp_type pix);
      int scr_col;
      int scr_row;
      int pad;
      bit drop;
      bit made;
      pix  = '0;
      made = 1'b0;
      if (beat_in.image_start) begin
         clear_counters();
      end
      if (pad_left != 0) begin
         pad_left = pad_left - 1'b1;
         if (pad_left == 0) begin
            next_source_row();
         end
         return 1'b0;
      end
      if (byte_phase == 2'd0) begin
         bg_hold[7:0] = beat_in.pixel_byte;
         byte_phase   = 2'd1;
         return 1'b0;
      end
      if (byte_phase == 2'd1) begin
         bg_hold[15:8] = beat_in.pixel_byte;
         byte_phase    = 2'd2;
         return 1'b0;
      end
      byte_phase = 2'd0;
      if (row_kept() && src_col == next_col && out_col < shadow.dst_width) begin
         scr_col = int'(shadow.origin_x) + int'(out_col);
         scr_row = int'(shadow.origin_y) + int'(shadow.dst_height) - 1 - int'(out_row);
         drop = shadow.clip_border && (scr_col == 0 || scr_col >= SCREEN_STRIDE - 1 ||
                scr_row == 0 || scr_row >= SCREEN_LAST_ROW);
         if (!drop) begin
            pix.fb_address = ADDR_BITS'(scr_col + scr_row * SCREEN_STRIDE);
            pix.pixel_word = {beat_in.pixel_byte, bg_hold};
            pix.image_done = (out_col == shadow.dst_width - 1'b1) &&
                             (out_row == shadow.dst_height - 1'b1);
            made = 1'b1;
         end
         out_col  = out_col + 1'b1;
         next_col = next_col + shadow.col_step;
      end
      if (src_col == shadow.src_width - 1'b1) begin
         pad = row_padding(int'(shadow.src_width));
         if (pad == 0) begin
            next_source_row();
         end else begin
            pad_left = 2'(pad);
         end
      end else begin
         src_col = src_col + 1'b1;
      end
      return made;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            pop_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 51;
            pop_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            pop_stall_pct = 51;
         end
         default: begin
            send_idle_pct = 35;
            pop_stall_pct = 35;
         end
      endcase
   endtask

   task automatic send_byte(input req_type beat, input bit use_given, input rsp_type given);
      rsp_type pix;
      bit      made;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (full);
      bytes_sent++;
      made = scale_byte(beat, pix);
      if (use_given) begin
         pending_pixels.push_back(given);
      end else if (made) begin
         pending_pixels.push_back(pix);
      end
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SRC_WIDTH;
      csr_wdata    <= c.src_width;
      @(posedge clock);
      csr_index    <= CSR_DST_WIDTH;
      csr_wdata    <= c.dst_width;
      @(posedge clock);
      csr_index    <= CSR_DST_HEIGHT;
      csr_wdata    <= c.dst_height;
      @(posedge clock);
      csr_index    <= CSR_COL_STEP;
      csr_wdata    <= c.col_step;
      @(posedge clock);
      csr_index    <= CSR_ROW_STEP;
      csr_wdata    <= c.row_step;
      @(posedge clock);
      csr_index    <= CSR_ORIGIN_X;
      csr_wdata    <= c.origin_x;
      @(posedge clock);
      csr_index    <= CSR_ORIGIN_Y;
      csr_wdata    <= c.origin_y;
      @(posedge clock);
      csr_index    <= CSR_CLIP_BORDER;
      csr_wdata    <= CSR_DATA_BITS'(c.clip_border);
      @(posedge clock);
      csr_write_en <= 1'b0;
      shadow = c;
   endtask

   task automatic send_raw(input int count);
      req_type beat;
      for (int i = 0; i < count; i++) begin
         beat.pixel_byte  = 8'($urandom_range(255));
         beat.image_start = (i == 0);
         send_byte(beat, 1'b0, '0);
      end
   endtask

   // One source image sized for the current settings; some are cut short,
   // run long, or are plain noise with stray image starts.
   task automatic send_image();
      req_type beat;
      int      w;
      int      rows;
      int      total;
      int      kind;
      w = (shadow.src_width == 0) ? 2048 : int'(shadow.src_width);
      rows = (shadow.row_step == 0) ? 1 :
             (int'(shadow.dst_height) - 1) * int'(shadow.row_step) + 1;
      rows  = rows + $urandom_range(1, 0);
      total = rows * (3 * w + row_padding(w));
      kind  = $urandom_range(9);
      if (kind == 7) begin
         total = $urandom_range(total, 1);
      end else if (kind == 8) begin
         total = total + $urandom_range(12, 1);
      end else if (kind == 9) begin
         total = $urandom_range(20, 1);
      end
      for (int i = 0; i < total; i++) begin
         beat.pixel_byte  = 8'($urandom_range(255));
         beat.image_start = (kind == 9) ? ($urandom_range(9) == 0) : (i == 0);
         send_byte(beat, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_pixels.size() == 0) begin
               flag_error($sformatf("unexpected pixel: addr %0d word %06h done %0b",
                  rsp_data.fb_address, rsp_data.pixel_word, rsp_data.image_done));
            end else begin
               want_pixel = pending_pixels.pop_front();
               if (rsp_data.fb_address !== want_pixel.fb_address ||
                   rsp_data.pixel_word !== want_pixel.pixel_word ||
                   rsp_data.image_done !== want_pixel.image_done) begin
                  flag_error($sformatf(
                     "pixel %0d: expected addr %0d word %06h done %0b, got %0d %06h %0b",
                     pixels_checked, want_pixel.fb_address, want_pixel.pixel_word,
                     want_pixel.image_done, rsp_data.fb_address, rsp_data.pixel_word,
                     rsp_data.image_done));
               end
            end
            pixels_checked++;
         end
         pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      cfg_type cfg;
      int      phase_start;
      bit      paused;
      shadow  = '{11'd800, 11'd800, 11'd480, 11'd1, 11'd1, 11'd0, 11'd0, 1'b0};
      bg_hold = '0;
      clear_counters();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_idling(IDLE_NONE);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_byte(directed[i].beat, directed[i].given, directed[i].want);
      end

      // Border clipping at the top-left and bottom-right corners.
      set_idling(IDLE_SENDER);
      apply_config('{11'd8, 11'd8, 11'd4, 11'd1, 11'd1, 11'd0, 11'd0, 1'b1});
      repeat (3) send_image();
      set_idling(IDLE_RECEIVER);
      apply_config('{11'd8, 11'd8, 11'd4, 11'd1, 11'd1, 11'd792, 11'd476, 1'b1});
      repeat (3) send_image();

      // Zero steps keep only the first column and the first source row.
      set_idling(IDLE_BOTH);
      apply_config('{11'd5, 11'd4, 11'd3, 11'd0, 11'd0, 11'd10, 11'd20, 1'b0});
      repeat (3) send_image();

      set_idling(IDLE_NONE);
      apply_config('{11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd0, 11'd0, 1'b0});
      repeat (3) send_image();

      // All registers but the clip flag at their maximum with a source far too short.
      set_idling(IDLE_SENDER);
      apply_config('{11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047,
                     11'd2047, 11'd2047, 1'b0});
      send_raw(30);

      // Zero width: no row ends within a short run, so the columns are picked
      // by the column step and the output width alone.
      set_idling(IDLE_BOTH);
      apply_config('{11'd0, 11'd5, 11'd2, 11'd3, 11'd1, 11'd100, 11'd100, 1'b1});
      send_raw(120);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         cfg.src_width  = 11'($urandom_range(8, 1));
         cfg.dst_width  = 11'($urandom_range(int'(cfg.src_width) + 1, 1));
         cfg.dst_height = 11'($urandom_range(4, 1));
         cfg.col_step   = 11'($urandom_range(3, 0));
         cfg.row_step   = 11'($urandom_range(2, 0));
         case ($urandom_range(3))
            0: cfg.origin_x = 11'($urandom_range(2, 0));
            1: cfg.origin_x = 11'($urandom_range(799, 790));
            2: cfg.origin_x = 11'($urandom_range(2047, 0));
            default: cfg.origin_x = 11'($urandom_range(500, 300));
         endcase
         case ($urandom_range(3))
            0: cfg.origin_y = 11'($urandom_range(2, 0));
            1: cfg.origin_y = 11'($urandom_range(479, 472));
            2: cfg.origin_y = 11'($urandom_range(2047, 0));
            default: cfg.origin_y = 11'($urandom_range(300, 100));
         endcase
         cfg.clip_border = 1'($urandom_range(1));
         set_idling(idle_mode_type'(p % 4));
         apply_config(cfg);
         phase_start = bytes_sent;
         paused      = 1'b0;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if (!paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            send_image();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/bmpfb_pkg.sv
rtl/bmpfb_link_queue.sv
rtl/bmpfb_front.sv
rtl/bmpfb_back.sv
rtl/bmp24_to_framebuffer_scaler.sv
rtl/bmpfb_checker.sv
tb/tb_bmp24_to_framebuffer_scaler.sv
